/* hw/rtl/reflow_profile_controller_macros.svh */
// Assertion macros for the reflow profile controller.
// Included by the top level; depends on nothing else.
`ifndef REFLOW_PROFILE_CONTROLLER_MACROS_SVH
`define REFLOW_PROFILE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
`define RPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPC_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define RPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPC_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

/* hw/rtl/rpc_pkg.sv */
// Shared widths, phase codes, register indexes and the configuration struct
// of the reflow profile controller. No dependencies.
package rpc_pkg;

  localparam int FRAME_W = 16;
  localparam int CODE_W  = 13;
  localparam int TEMP_W  = 10;
  localparam int SP_W    = 10;
  localparam int TICK_W  = 9;
  localparam int GAIN_W  = 12;
  localparam int DRIVE_W = 10;
  localparam int PHASE_W = 3;
  localparam int ERR_W   = SP_W + 1;
  localparam int OUT_W   = 24;
  localparam int FRAC_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  localparam logic [PHASE_W-1:0] PH_HEAT1  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SOAK   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HEAT2  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_REFLOW = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COOL   = 3'd4;

  localparam logic [IDX_W-1:0] REG_SOAK_SP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_REFLOW_SP   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOAK_TICKS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_REFLOW_TICKS = 3'd3;
  localparam logic [IDX_W-1:0] REG_ERROR_GAIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FB_GAIN     = 3'd5;

  localparam logic [SP_W-1:0]    RST_SOAK_SP      = 10'd160;
  localparam logic [SP_W-1:0]    RST_REFLOW_SP    = 10'd210;
  localparam logic [TICK_W-1:0]  RST_SOAK_TICKS   = 9'd120;
  localparam logic [TICK_W-1:0]  RST_REFLOW_TICKS = 9'd60;
  localparam logic [GAIN_W-1:0]  RST_ERROR_GAIN   = 12'd791;
  localparam logic [GAIN_W-1:0]  RST_FB_GAIN      = 12'd209;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 10'd999;

  typedef struct packed {
    logic [SP_W-1:0]   soak_setpoint;
    logic [SP_W-1:0]   reflow_setpoint;
    logic [TICK_W-1:0] soak_ticks;
    logic [TICK_W-1:0] reflow_ticks;
    logic [GAIN_W-1:0] error_gain;
    logic [GAIN_W-1:0] feedback_gain;
  } cfg_t;

endpackage

/* hw/rtl/rpc_regs.sv */
// APB-style configuration register file of the reflow profile controller.
// Depends on rpc_pkg.
module rpc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpc_pkg::DATA_W-1:0]  pwdata,
  output logic [rpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rpc_pkg::cfg_t               cfg_o
);
  import rpc_pkg::*;

  cfg_t             cfg_q;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.soak_setpoint   <= RST_SOAK_SP;
      cfg_q.reflow_setpoint <= RST_REFLOW_SP;
      cfg_q.soak_ticks      <= RST_SOAK_TICKS;
      cfg_q.reflow_ticks    <= RST_REFLOW_TICKS;
      cfg_q.error_gain      <= RST_ERROR_GAIN;
      cfg_q.feedback_gain   <= RST_FB_GAIN;
    end else if (wr_en) begin
      case (idx)
        REG_SOAK_SP:      cfg_q.soak_setpoint   <= pwdata[SP_W-1:0];
        REG_REFLOW_SP:    cfg_q.reflow_setpoint <= pwdata[SP_W-1:0];
        REG_SOAK_TICKS:   cfg_q.soak_ticks      <= pwdata[TICK_W-1:0];
        REG_REFLOW_TICKS: cfg_q.reflow_ticks    <= pwdata[TICK_W-1:0];
        REG_ERROR_GAIN:   cfg_q.error_gain      <= pwdata[GAIN_W-1:0];
        REG_FB_GAIN:      cfg_q.feedback_gain   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SOAK_SP:      prdata = {{(DATA_W-SP_W){1'b0}}, cfg_q.soak_setpoint};
      REG_REFLOW_SP:    prdata = {{(DATA_W-SP_W){1'b0}}, cfg_q.reflow_setpoint};
      REG_SOAK_TICKS:   prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.soak_ticks};
      REG_REFLOW_TICKS: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.reflow_ticks};
      REG_ERROR_GAIN:   prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.error_gain};
      REG_FB_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.feedback_gain};
      default:          prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/rpc_seq.sv */
// Profile phase sequencer with the saturating soak/reflow tick timer.
// Depends on rpc_pkg.
module rpc_seq #(
  parameter int TIMER_BITS = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [rpc_pkg::TEMP_W-1:0]   temp_i,
  input  rpc_pkg::cfg_t                cfg_i,
  output logic [rpc_pkg::PHASE_W-1:0]  phase_o
);
  import rpc_pkg::*;

  localparam int CMP_W = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [PHASE_W-1:0]    phase_q, phase_d, phase;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
  logic                  timer_full, soak_done, reflow_done;

  // Unused codes behave as first heat
  assign phase   = (phase_q > PH_COOL) ? PH_HEAT1 : phase_q;
  assign phase_o = phase;

  assign timer_full  = (timer_q == TIMER_MAX);
  assign timer_inc   = timer_full ? timer_q : timer_q + TIMER_BITS'(1);
  assign soak_done   = (CMP_W'(timer_inc) >= CMP_W'(cfg_i.soak_ticks)) ||
                       (timer_inc == TIMER_MAX);
  assign reflow_done = (CMP_W'(timer_inc) >= CMP_W'(cfg_i.reflow_ticks)) ||
                       (timer_inc == TIMER_MAX);

  always_comb begin
    phase_d = phase;
    timer_d = timer_q;
    case (phase)
      PH_HEAT1: begin
        if (temp_i >= cfg_i.soak_setpoint) begin
          phase_d = PH_SOAK;
          timer_d = '0;
        end
      end
      PH_SOAK: begin
        timer_d = timer_inc;
        if (soak_done) begin
          phase_d = PH_HEAT2;
          timer_d = '0;
        end
      end
      PH_HEAT2: begin
        if (temp_i >= cfg_i.reflow_setpoint) begin
          phase_d = PH_REFLOW;
          timer_d = '0;
        end
      end
      PH_REFLOW: begin
        timer_d = timer_inc;
        if (reflow_done) begin
          phase_d = PH_COOL;
          timer_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAT1;
      timer_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
    end
  end

endmodule

/* hw/rtl/rpc_ctrl.sv */
// First-order controller: u = ge*e_prev + floor(gf*u_prev/256), saturated to
// 24 bits, and the clamped heater drive. Depends on rpc_pkg.
module rpc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [rpc_pkg::TEMP_W-1:0]   temp_i,
  input  logic [rpc_pkg::PHASE_W-1:0]  phase_i,
  input  rpc_pkg::cfg_t                cfg_i,
  output logic [rpc_pkg::DRIVE_W-1:0]  drive_o
);
  import rpc_pkg::*;

  localparam int FB_W  = GAIN_W + 1 + OUT_W - FRAC_W;
  localparam int SUM_W = FB_W + 1;
  localparam int WH_W  = OUT_W - FRAC_W;
  localparam int PE_W  = GAIN_W + ERR_W + 1;
  localparam int PF_W  = GAIN_W + OUT_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [ERR_W-1:0]          err_q, err_d;
  logic signed [OUT_W-1:0]          u_q, u_d;
  logic signed [GAIN_W:0]           eg_s, fg_s;
  logic signed [PE_W-1:0]           prod_e;
  logic signed [PF_W-1:0]           prod_f;
  logic signed [FB_W-1:0]           fb_sh;
  logic signed [SUM_W-1:0]          sum;
  logic signed [WH_W-1:0]           whole;
  logic [SP_W-1:0]                  sp;

  assign sp = (phase_i == PH_HEAT1 || phase_i == PH_SOAK) ?
              cfg_i.soak_setpoint : cfg_i.reflow_setpoint;

  assign eg_s   = $signed({1'b0, cfg_i.error_gain});
  assign fg_s   = $signed({1'b0, cfg_i.feedback_gain});
  assign prod_e = PE_W'(eg_s) * PE_W'(err_q);
  assign prod_f = PF_W'(fg_s) * PF_W'(u_q);
  // drop the fraction bits: arithmetic shift floors toward minus infinity
  assign fb_sh  = $signed(prod_f[GAIN_W+OUT_W:FRAC_W]);
  assign sum    = SUM_W'(prod_e) + SUM_W'(fb_sh);

  always_comb begin
    if (sum > SAT_HI) begin
      u_d = SAT_HI[OUT_W-1:0];
    end else if (sum < SAT_LO) begin
      u_d = SAT_LO[OUT_W-1:0];
    end else begin
      u_d = sum[OUT_W-1:0];
    end
  end

  assign err_d = $signed({1'b0, sp}) - $signed({1'b0, temp_i});
  assign whole = u_d[OUT_W-1:FRAC_W];

  always_comb begin
    if (phase_i == PH_COOL || whole[WH_W-1]) begin
      drive_o = '0;
    end else if (whole[WH_W-2:0] > (WH_W-1)'(DRIVE_MAX)) begin
      drive_o = DRIVE_MAX;
    end else begin
      drive_o = whole[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
      u_q   <= '0;
    end else if (step_i) begin
      err_q <= err_d;
      u_q   <= u_d;
    end
  end

endmodule

/* hw/rtl/reflow_profile_controller.sv */
// Top level of the reflow profile controller: input register, temperature
// conversion and result register. Uses rpc_pkg, rpc_regs, rpc_seq, rpc_ctrl.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_ready_o | raw_frame_i
//   out     | output    | out_valid_o/out_ready_i | drive_o, phase_o, temperature_o
//   cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// One transfer per cycle sustained while the output is not stalled. An input
// transfer reaches result valid via the input register, then controller/sequencer
// into the result register. The multiplier pair in the controller sets the critical path.
// Reset clears control state and loads the register defaults; no clearing pass.
// A stalled output keeps the result; one more item is held in the input register.
`include "reflow_profile_controller_macros.svh"

module reflow_profile_controller #(
  parameter int TIMER_BITS = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rpc_pkg::FRAME_W-1:0]   raw_frame_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rpc_pkg::DRIVE_W-1:0]   drive_o,
  output logic [rpc_pkg::PHASE_W-1:0]   phase_o,
  output logic [rpc_pkg::TEMP_W-1:0]    temperature_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [rpc_pkg::DATA_W-1:0]    pwdata,
  output logic [rpc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import rpc_pkg::*;

  localparam int SCL_W = CODE_W + 8;

  cfg_t               cfg;
  logic               s1_valid_q;
  logic [FRAME_W-1:0] frame_q;
  logic               out_valid_q;
  logic [DRIVE_W-1:0] drive_q, drive_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [TEMP_W-1:0]  temp_q, temp_d;
  logic               out_free, step, in_xfer;
  logic [CODE_W-1:0]  code;
  logic [SCL_W-1:0]   scaled;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // code * 255 / 1024, saturated to ten bits
  assign code   = frame_q[FRAME_W-1:FRAME_W-CODE_W];
  assign scaled = {code, 8'b0} - {8'b0, code};
  assign temp_d = scaled[SCL_W-1] ? {TEMP_W{1'b1}} : scaled[SCL_W-2:SCL_W-1-TEMP_W];

  rpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rpc_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .temp_i  (temp_d),
    .cfg_i   (cfg),
    .phase_o (phase_d)
  );

  rpc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .temp_i  (temp_d),
    .phase_i (phase_d),
    .cfg_i   (cfg),
    .drive_o (drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      frame_q <= raw_frame_i;
    end
    if (step) begin
      drive_q <= drive_d;
      phase_q <= phase_d;
      temp_q  <= temp_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign phase_o       = phase_q;
  assign temperature_o = temp_q;

  `RPC_ASSERT(a_cool_no_drive, clk_i, rst_ni, (out_valid_o && phase_o == PH_COOL) |-> (drive_o == '0), "drive active in cool phase")
  `RPC_ASSERT(a_drive_range, clk_i, rst_ni, out_valid_o |-> (drive_o <= DRIVE_MAX), "drive above limit")
  `RPC_ASSERT_NEVER(a_ready_stall, clk_i, rst_ni, !in_ready_o && !(s1_valid_q && out_valid_q && !out_ready_i), "input stalled without a full pipeline")

endmodule
